// ===== rtl/morse_keyer_assert.svh =====
// ----------------------------------------------------------------------------
// Morse keyer assertion macros
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEYER_ASSERT_SVH
`define MORSE_KEYER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every edge outside reset.
`define MK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("morse keyer assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define MK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("morse keyer assertion failed");
`else
`define MK_ASSERT(lbl, prop)
`define MK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/mk_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse keyer package
// Payload types, command codes, queue sizing and the letter table.
// ----------------------------------------------------------------------------
package mk_pkg;

  localparam int DOT_MS_W   = 10;
  localparam int COUNT_W    = 13;
  localparam int LETTER_W   = 5;
  localparam int ELEM_W     = 3;

  localparam logic [DOT_MS_W-1:0] DOT_MS_RESET = 10'd100;

  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_Z     = 8'h7A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic led;
    logic busy_res;
    logic dropped;
  } out_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LETTER,
    CMD_SPACE,
    CMD_OTHER
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [LETTER_W-1:0]   letter;
  } cmd_t;

  // Element count in [6:4], dash flags per element in [3:0]
  function automatic logic [7:0] morse_entry(logic [LETTER_W-1:0] idx);
    logic [7:0] e;
    unique case (idx)
      5'd0:  e = 8'h22;
      5'd1:  e = 8'h41;
      5'd2:  e = 8'h45;
      5'd3:  e = 8'h31;
      5'd4:  e = 8'h10;
      5'd5:  e = 8'h44;
      5'd6:  e = 8'h33;
      5'd7:  e = 8'h40;
      5'd8:  e = 8'h20;
      5'd9:  e = 8'h4E;
      5'd10: e = 8'h35;
      5'd11: e = 8'h42;
      5'd12: e = 8'h23;
      5'd13: e = 8'h21;
      5'd14: e = 8'h37;
      5'd15: e = 8'h46;
      5'd16: e = 8'h4B;
      5'd17: e = 8'h32;
      5'd18: e = 8'h30;
      5'd19: e = 8'h11;
      5'd20: e = 8'h34;
      5'd21: e = 8'h48;
      5'd22: e = 8'h36;
      5'd23: e = 8'h49;
      5'd24: e = 8'h4D;
      5'd25: e = 8'h43;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/mk_front.sv =====
// ----------------------------------------------------------------------------
// Morse keyer front end
// Classify each incoming transaction into a tick, letter, space or other.
// ----------------------------------------------------------------------------
module mk_front (
  input  mk_pkg::in_t  in_data_i,
  output mk_pkg::cmd_t cmd_o
);
  import mk_pkg::*;

  logic [7:0] letter_off;

  assign letter_off = in_data_i.char_code - CHAR_A;

  always_comb begin
    cmd_o.letter = letter_off[LETTER_W-1:0];
    priority if (!in_data_i.op) begin
      cmd_o.kind = CMD_TICK;
    end else if (in_data_i.char_code >= CHAR_A && in_data_i.char_code <= CHAR_Z) begin
      cmd_o.kind = CMD_LETTER;
    end else if (in_data_i.char_code == CHAR_SPACE) begin
      cmd_o.kind = CMD_SPACE;
    end else begin
      cmd_o.kind = CMD_OTHER;
    end
  end

endmodule

// ===== rtl/mk_fifo.sv =====
// ----------------------------------------------------------------------------
// Morse keyer command queue
// Short queue that decouples the classifier from the keying engine.
// ----------------------------------------------------------------------------
module mk_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  mk_pkg::cmd_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output mk_pkg::cmd_t pop_data_o
);
  import mk_pkg::*;

  localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_FULL);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mk_back.sv =====
// ----------------------------------------------------------------------------
// Morse keyer back end
// Keying state machine and output register; one command per cycle while not stalled.
// ----------------------------------------------------------------------------
module mk_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mk_pkg::DOT_MS_W-1:0]   dot_ms_i,
  input  logic                          cmd_valid_i,
  input  mk_pkg::cmd_t                  cmd_i,
  output logic                          cmd_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mk_pkg::out_t                  out_data_o
);
  import mk_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_DARK = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  logic [1:0]          phase_q, phase_d;
  logic [LETTER_W-1:0] letter_q, letter_d;
  logic [ELEM_W-1:0]   elem_q, elem_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                dropped_d;
  logic                out_valid_q;
  out_t                out_q;

  logic [COUNT_W-1:0]  unit1, unit3, unit7;
  logic [LETTER_W-1:0] ld_letter;
  logic [ELEM_W-1:0]   ld_elem;
  logic [7:0]          ld_entry;
  logic [1:0]          el_phase;
  logic [COUNT_W-1:0]  el_count;

  assign unit1 = COUNT_W'(dot_ms_i);
  assign unit3 = unit1 + (unit1 << 1);
  assign unit7 = (unit1 << 3) - unit1;

  // Element load: first element of a new letter, or the next one of this letter
  assign ld_letter = (cmd_i.kind == CMD_LETTER) ? cmd_i.letter : letter_q;
  assign ld_elem   = (cmd_i.kind == CMD_LETTER) ? '0 : elem_q + 1'b1;
  assign ld_entry  = morse_entry(ld_letter);

  always_comb begin
    if (ld_elem < ld_entry[6:4]) begin
      el_phase = PH_LIT;
      el_count = ld_entry[ld_elem[1:0]] ? unit3 : unit1;
    end else begin
      el_phase = PH_GAP;
      el_count = unit3;
    end
  end

  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    phase_d   = phase_q;
    letter_d  = letter_q;
    elem_d    = elem_q;
    count_d   = count_q;
    dropped_d = 1'b0;
    if (cmd_i.kind == CMD_TICK) begin
      if (phase_q != PH_IDLE) begin
        if (count_q > COUNT_W'(1)) begin
          count_d = count_q - 1'b1;
        end else begin
          unique case (phase_q)
            PH_LIT: begin
              phase_d = PH_DARK;
              count_d = unit1;
            end
            PH_DARK: begin
              elem_d  = ld_elem;
              phase_d = el_phase;
              count_d = el_count;
            end
            PH_GAP: begin
              phase_d = PH_IDLE;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
    end else if (phase_q != PH_IDLE) begin
      dropped_d = 1'b1;
    end else begin
      unique case (cmd_i.kind)
        CMD_LETTER: begin
          letter_d = ld_letter;
          elem_d   = ld_elem;
          phase_d  = el_phase;
          count_d  = el_count;
        end
        CMD_SPACE: begin
          phase_d = PH_GAP;
          count_d = unit7;
        end
        default: begin
          phase_d = PH_GAP;
          count_d = unit3;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      letter_q    <= '0;
      elem_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        phase_q     <= phase_d;
        letter_q    <= letter_d;
        elem_q      <= elem_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q.led      <= (phase_d == PH_LIT);
      out_q.busy_res <= (phase_d != PH_IDLE);
      out_q.dropped  <= dropped_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/morse_keyer.sv =====
// ----------------------------------------------------------------------------
// Morse keyer top level
// Keys lowercase text as International Morse code, one result per input.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): each transaction is
//   either a one-millisecond tick (op = 0) or a character (op = 1).
//   Output channel (out_valid_o / out_stall_i / out_data_o): one transaction
//   per input, in order, with the light level, busy flag and drop flag.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes dot_ms,
//   the unit length in ticks; always ready; write it only while idle.
// Path: an accepted input is first stored in the command queue, then the
//   keying engine registers its result in the output register.
// Throughput: one transaction per cycle unless out_stall_i holds; the
//   keying engine does a constant-time update per command with its multiply
//   by 1, 3 or 7 done with shifts, an add and a subtract.
// Stall: when out_stall_i holds, a valid result stays in its register; the two-entry
//   command queue keeps taking input until full, then raises in_stall_o.
// Reset: idle, dot_ms = 100, queue and output register empty. No clearing
//   pass.
// ----------------------------------------------------------------------------
module morse_keyer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mk_pkg::in_t                  in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mk_pkg::out_t                 out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mk_pkg::DOT_MS_W-1:0]  cfg_data_i
);
  import mk_pkg::*;

  `include "morse_keyer_assert.svh"

  logic [DOT_MS_W-1:0] dot_ms_q;
  cmd_t                front_cmd;
  cmd_t                queue_cmd;
  logic                queue_full;
  logic                queue_valid;
  logic                cmd_pop;
  logic                in_push;

  // Config register: always ready, take the write data as it stands
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ms_q <= DOT_MS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dot_ms_q <= cfg_data_i;
    end
  end

  // Stall the input only when the queue is full
  assign in_stall_o = queue_full;
  assign in_push    = in_valid_i && !queue_full;

  mk_front u_front (
    .in_data_i (in_data_i),
    .cmd_o     (front_cmd)
  );

  mk_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_push),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (cmd_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_cmd)
  );

  mk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dot_ms_i    (dot_ms_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A dropped character leaves the engine busy; a lit output means busy
  `MK_ASSERT(drop_while_busy, !(out_valid_o && out_data_o.dropped) || out_data_o.busy_res)
  `MK_ASSERT(led_implies_busy, !(out_valid_o && out_data_o.led) || out_data_o.busy_res)
  // Every accepted transaction reaches the queue, every popped one the output
  `MK_ASSERT_NEXT(push_lands_in_queue, in_valid_i && !in_stall_o, queue_valid)
  `MK_ASSERT_NEXT(pop_fills_output, cmd_pop, out_valid_o)

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Morse keyer testbench
// Drives ticks and characters into the keyer, with bursts and gaps on the
// input and a changing stall pattern on the output. Every result transaction
// is checked field by field against a typed row's result or a cycle-free model.
// A short scripted part covers reset, range edges and the unit corner cases.
// Random phases follow, each at its own dot unit.
// ----------------------------------------------------------------------------
module testbench;
  import mk_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LETTERS        = 26;

  localparam logic [2:0] DOT_UNITS      = 3'd1;
  localparam logic [2:0] DASH_UNITS     = 3'd3;
  localparam logic [2:0] CHAR_GAP_UNITS = 3'd3;
  localparam logic [2:0] WORD_GAP_UNITS = 3'd7;

  typedef enum logic {OP_TICK = 1'b0, OP_CHAR = 1'b1} key_op_e;
  typedef enum logic [1:0] {KEY_IDLE, KEY_MARK, KEY_SPACE, KEY_GAP} key_phase_e;
  typedef enum logic {ROW_ITEM, ROW_UNIT} row_kind_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  // Letter shapes: element count in [6:4], dash flag per element in [3:0]
  localparam logic [6:0] MORSE_SHAPE [LETTERS] = '{
    7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20,
    7'h4E, 7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32,
    7'h30, 7'h11, 7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
  };

  typedef struct packed {
    row_kind_e             kind;
    key_op_e               op;
    logic [7:0]            chr;
    logic [11:0]           reps;
    logic                  typed;
    out_t                  want;
    logic [DOT_MS_W-1:0]   unit;
  } script_row_t;

  // Scripted part. A typed row carries its expected result; the others go
  // through the model. Tick rows with a repeat count drain the keyer.
  localparam int SCRIPT_ROWS = 25;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_ITEM, OP_TICK, 8'h00, 12'd1,   1'b1, 3'b000, 10'd0},   // idle after reset
    '{ROW_ITEM, OP_CHAR, "e",   12'd1,   1'b1, 3'b110, 10'd0},   // dot lights at once
    '{ROW_ITEM, OP_CHAR, "q",   12'd1,   1'b1, 3'b111, 10'd0},   // busy, dropped
    '{ROW_UNIT, OP_TICK, 8'h00, 12'd0,   1'b0, 3'b000, 10'd1},   // unit change mid-dot
    '{ROW_ITEM, OP_TICK, 8'hA5, 12'd104, 1'b0, 3'b000, 10'd0},   // reset unit runs out
    '{ROW_ITEM, OP_TICK, 8'h5A, 12'd1,   1'b1, 3'b000, 10'd0},   // tick while idle
    '{ROW_ITEM, OP_CHAR, "a",   12'd1,   1'b1, 3'b110, 10'd0},
    '{ROW_ITEM, OP_TICK, 8'hFF, 12'd10,  1'b0, 3'b000, 10'd0},
    '{ROW_ITEM, OP_CHAR, "z",   12'd1,   1'b1, 3'b110, 10'd0},
    '{ROW_ITEM, OP_TICK, 8'h00, 12'd16,  1'b0, 3'b000, 10'd0},
    '{ROW_ITEM, OP_CHAR, " ",   12'd1,   1'b1, 3'b010, 10'd0},   // word gap
    '{ROW_ITEM, OP_CHAR, "z",   12'd1,   1'b1, 3'b011, 10'd0},   // dropped in gap
    '{ROW_ITEM, OP_TICK, 8'h3C, 12'd7,   1'b0, 3'b000, 10'd0},
    '{ROW_ITEM, OP_CHAR, 8'h00, 12'd1,   1'b1, 3'b010, 10'd0},   // other: char gap
    '{ROW_ITEM, OP_TICK, 8'hC3, 12'd3,   1'b0, 3'b000, 10'd0},
    '{ROW_ITEM, OP_CHAR, 8'hFF, 12'd1,   1'b1, 3'b010, 10'd0},
    '{ROW_ITEM, OP_TICK, 8'h81, 12'd3,   1'b0, 3'b000, 10'd0},
    '{ROW_ITEM, OP_CHAR, 8'h60, 12'd1,   1'b1, 3'b010, 10'd0},   // just below 'a'
    '{ROW_ITEM, OP_TICK, 8'h7E, 12'd3,   1'b0, 3'b000, 10'd0},
    '{ROW_ITEM, OP_CHAR, 8'h7B, 12'd1,   1'b1, 3'b010, 10'd0},   // just above 'z'
    '{ROW_ITEM, OP_TICK, 8'h18, 12'd3,   1'b0, 3'b000, 10'd0},
    '{ROW_UNIT, OP_TICK, 8'h00, 12'd0,   1'b0, 3'b000, 10'd0},   // zero unit
    '{ROW_ITEM, OP_CHAR, "t",   12'd1,   1'b1, 3'b110, 10'd0},
    '{ROW_ITEM, OP_TICK, 8'hE7, 12'd3,   1'b0, 3'b000, 10'd0},
    '{ROW_ITEM, OP_TICK, 8'h42, 12'd1,   1'b1, 3'b000, 10'd0}    // back to idle
  };

  // Random phases: dot unit and number of transactions that do real work
  localparam int PHASES = 8;
  localparam logic [DOT_MS_W-1:0] PHASE_UNIT [PHASES] = '{
    10'd2, 10'd1, 10'd0, 10'd3, 10'd1, 10'd5, 10'd2, 10'd1023
  };
  localparam int PHASE_ITEMS [PHASES] = '{60, 60, 50, 60, 55, 55, 60, 30};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [DOT_MS_W-1:0] cfg_data = '0;

  // Model of the keying state
  key_phase_e            key_phase;
  logic [LETTER_W-1:0]   key_letter;
  logic [ELEM_W-1:0]     key_elem;
  logic [COUNT_W-1:0]    key_count;
  logic [DOT_MS_W-1:0]   unit_ms;

  out_t        expected_light_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  int          idle_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  morse_keyer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void start_gap(logic [2:0] units);
    key_phase = KEY_GAP;
    key_count = units * unit_ms;
  endfunction

  // Load the current element of the letter, or the closing gap after the last
  function automatic void start_element();
    if (key_elem < MORSE_SHAPE[key_letter][6:4]) begin
      key_phase = KEY_MARK;
      key_count = (MORSE_SHAPE[key_letter][key_elem[1:0]] ? DASH_UNITS : DOT_UNITS) * unit_ms;
    end else begin
      start_gap(CHAR_GAP_UNITS);
    end
  endfunction

  // Advance the keying state by one transaction and return the light level, busy and drop flags
  function automatic out_t key_light_step(in_t item);
    out_t r;
    r = '0;
    if (item.op == OP_CHAR) begin
      if (key_phase != KEY_IDLE) begin
        r.dropped = 1'b1;
      end else if (item.char_code >= CHAR_A && item.char_code <= CHAR_Z) begin
        key_letter = LETTER_W'(item.char_code - CHAR_A);
        key_elem = '0;
        start_element();
      end else if (item.char_code == CHAR_SPACE) begin
        start_gap(WORD_GAP_UNITS);
      end else begin
        start_gap(CHAR_GAP_UNITS);
      end
    end else if (key_phase != KEY_IDLE) begin
      // A count of zero ends on the next tick, same as a count of one
      if (key_count > 1) begin
        key_count = key_count - 1'b1;
      end else begin
        case (key_phase)
          KEY_MARK: begin
            key_phase = KEY_SPACE;
            key_count = unit_ms;
          end
          KEY_SPACE: begin
            key_elem = key_elem + 1'b1;
            start_element();
          end
          default: begin
            key_phase = KEY_IDLE;
            key_count = '0;
          end
        endcase
      end
    end
    r.led = (key_phase == KEY_MARK);
    r.busy_res = (key_phase != KEY_IDLE);
    return r;
  endfunction

  // Mostly whole letters with enough ticks to play them out; while busy,
  // now and then a character that the keyer has to drop.
  function automatic in_t pick_item();
    in_t item;
    int  roll;
    item.char_code = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (key_phase == KEY_IDLE) begin
      item.op = (roll < 75) ? OP_CHAR : OP_TICK;
      roll = $urandom_range(0, 99);
      if (item.op == OP_CHAR && roll < 70) begin
        item.char_code = 8'($urandom_range(CHAR_A, CHAR_Z));
      end else if (item.op == OP_CHAR && roll < 80) begin
        item.char_code = CHAR_SPACE;
      end
    end else begin
      item.op = (roll < 92) ? OP_TICK : OP_CHAR;
    end
    return item;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // Send one input transaction, opening a gap first when a burst runs out
  task automatic key_item(input in_t item, input logic typed, input out_t want,
                          output out_t got);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = key_light_step(item);
    expected_light_q.push_back(typed ? want : got);
  endtask

  // Write the dot unit once every result is back; the keyer may still be
  // playing, in which case the running segment keeps its count.
  task automatic set_unit(input logic [DOT_MS_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_light_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unit_ms = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_t  item;
    out_t got;
    int   n;
    int   k;
    bit   idle_before;
    key_phase  = KEY_IDLE;
    key_letter = '0;
    key_elem   = '0;
    key_count  = '0;
    unit_ms    = DOT_MS_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the script
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_UNIT) begin
        set_unit(SCRIPT[i].unit);
      end else begin
        for (k = 0; k < SCRIPT[i].reps; k++) begin
          item.op = SCRIPT[i].op;
          item.char_code = SCRIPT[i].chr;
          key_item(item, SCRIPT[i].typed, SCRIPT[i].want, got);
        end
      end
    end

    // Random phases; dropped characters and idle ticks do not count
    foreach (PHASE_UNIT[p]) begin
      set_unit(PHASE_UNIT[p]);
      steady = ($urandom_range(0, 2) == 0);
      n = 0;
      while (n < PHASE_ITEMS[p]) begin
        item = pick_item();
        idle_before = (key_phase == KEY_IDLE);
        key_item(item, 1'b0, '0, got);
        if (!(got.dropped || (item.op == OP_TICK && idle_before))) n++;
      end
    end

    in_valid <= 1'b0;
    while (expected_light_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_light_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %b", out_data));
      end else begin
        want = expected_light_q.pop_front();
        if (out_data.led !== want.led)
          report_mismatch($sformatf("led %b, expected %b", out_data.led, want.led));
        if (out_data.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, expected %b",
                                    out_data.busy_res, want.busy_res));
        if (out_data.dropped !== want.dropped)
          report_mismatch($sformatf("dropped %b, expected %b",
                                    out_data.dropped, want.dropped));
      end
      results_seen++;
    end
  end

  // Output stall: hold each mode for a random stretch, including no stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  // Drop the run when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
